// File: hdl/sop_pkg.sv
// Shared types and constants for the set-of-stacks block.
// No dependencies; every other file refers to it by scoped names.
package sop_pkg;

  localparam int DATA_W   = 32;
  localparam int CAP_W    = 7;
  localparam int ACTION_W = 2;
  localparam int SIDX_W   = 6;
  localparam int COUNT_W  = 7;
  // Wide enough for stack_index * capacity + capacity - 1 and any count.
  localparam int CALC_W   = 14;
  localparam logic [CAP_W-1:0] CAP_RESET = 7'd3;

  typedef enum logic [ACTION_W-1:0] {
    ACT_PUSH   = 2'd0,
    ACT_POP    = 2'd1,
    ACT_POP_AT = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FULL      = 2'd2,
    ST_BAD_INDEX = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CC_HOLD,
    CC_PUSH,
    CC_POP,
    CC_SWAP
  } cell_cmd_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SWAP,
    S_FINISH
  } state_t;

endpackage

// File: hdl/sop_if.sv
// Valid/ready channel interfaces for requests, responses and configuration.
// Depends on sop_pkg for field widths.
interface sop_req_if;
  logic                               valid;
  logic                               ready;
  logic [sop_pkg::ACTION_W-1:0]       action;
  logic signed [sop_pkg::DATA_W-1:0]  push_value;
  logic [sop_pkg::SIDX_W-1:0]         stack_index;
  modport source (output valid, action, push_value, stack_index, input ready);
  modport sink   (input valid, action, push_value, stack_index, output ready);
endinterface

interface sop_rsp_if;
  logic                               valid;
  logic                               ready;
  logic signed [sop_pkg::DATA_W-1:0]  popped_value;
  logic [1:0]                         status;
  logic [sop_pkg::COUNT_W-1:0]        element_count;
  modport source (output valid, popped_value, status, element_count, input ready);
  modport sink   (input valid, popped_value, status, element_count, output ready);
endinterface

interface sop_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [sop_pkg::CAP_W-1:0]   plate_capacity;
  modport source (output valid, plate_capacity, input ready);
  modport sink   (input valid, plate_capacity, output ready);
endinterface

// File: hdl/set_of_stacks_with_pop_at_top.sv
// Top level of the set-of-stacks block; builds a row of sop_cell instances.
// Depends on sop_pkg and the channel interfaces in sop_if.sv.
//
// A bounded stack of up to TOTAL_DEPTH signed 32-bit values, grouped into
// sub-stacks of plate_capacity values (a capacity of zero acts as one). The
// values sit in a row of cells with the top of the stack in cell 0, so a push
// shifts the whole row one cell deeper and a pop shifts it one cell up. For
// push, pop and every failing item (empty, full, bad sub-stack index) the
// response register loads at the transfer edge and offers the result from
// the next cycle, and a new request can be taken every cycle while the block
// is idle and responses drain. A pop_at whose target lies t places below the
// top (t at least one) holds the block through the accepting cycle, t
// adjacent swaps that walk the target up to cell 0, and an ordinary pop that
// loads the result. The final pop waits while an earlier response is still
// unread. Requests are held off from the transfer until that pop. The
// capacity register is written through its own channel, which is always
// ready; write it only while the block is idle. element_count carries the
// low 7 bits of the stored count.
module set_of_stacks_with_pop_at_top #(
  parameter int TOTAL_DEPTH = 64
) (
  input logic      clk,
  input logic      rst,
  sop_req_if.sink  req,
  sop_rsp_if.source rsp,
  sop_cfg_if.sink  cfg
);

  localparam int IW = $clog2(TOTAL_DEPTH);
  localparam int CW = $clog2(TOTAL_DEPTH + 1);
  localparam int XW = sop_pkg::CALC_W;
  localparam int DW = sop_pkg::DATA_W;

  // control registers
  sop_pkg::state_t              state, state_next;
  logic [CW-1:0]                count, count_next;
  logic [IW-1:0]                swap_pos, swap_pos_next;
  logic [sop_pkg::CAP_W-1:0]    plate_capacity;

  // response register
  logic                         rsp_valid;
  logic [DW-1:0]                rsp_value;
  sop_pkg::status_t             rsp_status;
  logic [sop_pkg::COUNT_W-1:0]  rsp_count;

  // row of cells
  sop_pkg::cell_cmd_t           cmd;
  logic [DW-1:0]                cell_value [TOTAL_DEPTH];

  // request decode
  logic                         accept;
  logic                         slot_free;
  logic [sop_pkg::CAP_W-1:0]    cap_eff;
  logic [XW-1:0]                prod;
  logic [XW-1:0]                pos_raw;
  logic [XW-1:0]                last;
  logic [XW-1:0]                pos;
  logic [IW-1:0]                depth_from_top;
  logic                         is_empty;
  logic                         is_full;
  logic                         bad_index;

  // result to load
  logic                         res_load;
  logic [DW-1:0]                res_value;
  sop_pkg::status_t             res_status;

  // Always take capacity writes.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      plate_capacity <= sop_pkg::CAP_RESET;
    end else if (cfg.valid) begin
      plate_capacity <= cfg.plate_capacity;
    end
  end

  // Accept only when idle and the response slot is empty or draining.
  assign slot_free = !rsp_valid || rsp.ready;
  assign req.ready = (state == sop_pkg::S_IDLE) && slot_free;
  assign accept    = req.valid && req.ready;

  // Locate the pop_at target: flat position min(i*cap + cap - 1, count - 1),
  // turned into a distance below the top of the row.
  assign cap_eff   = (plate_capacity == '0) ? sop_pkg::CAP_W'(1) : plate_capacity;
  assign prod      = XW'(req.stack_index) * XW'(cap_eff);
  assign pos_raw   = prod + XW'(cap_eff) - XW'(1);
  assign last      = XW'(count) - XW'(1);
  assign pos       = (pos_raw > last) ? last : pos_raw;
  assign depth_from_top = IW'(last - pos);
  assign is_empty  = (count == '0);
  assign is_full   = (count == CW'(TOTAL_DEPTH));
  assign bad_index = (prod >= XW'(count));

  always_comb begin
    state_next    = state;
    count_next    = count;
    swap_pos_next = swap_pos;
    cmd           = sop_pkg::CC_HOLD;
    res_load      = 1'b0;
    res_value     = '0;
    res_status    = sop_pkg::ST_OK;
    unique case (state)
      sop_pkg::S_IDLE: begin
        if (accept) begin
          res_load = 1'b1;
          unique case (req.action)
            sop_pkg::ACT_PUSH: begin
              if (is_full) begin
                res_status = sop_pkg::ST_FULL;
              end else begin
                cmd        = sop_pkg::CC_PUSH;
                count_next = count + CW'(1);
              end
            end
            sop_pkg::ACT_POP: begin
              if (is_empty) begin
                res_status = sop_pkg::ST_EMPTY;
              end else begin
                cmd        = sop_pkg::CC_POP;
                res_value  = cell_value[0];
                count_next = count - CW'(1);
              end
            end
            sop_pkg::ACT_POP_AT: begin
              if (is_empty) begin
                res_status = sop_pkg::ST_EMPTY;
              end else if (bad_index) begin
                res_status = sop_pkg::ST_BAD_INDEX;
              end else if (depth_from_top == '0) begin
                // target already on top: plain pop
                cmd        = sop_pkg::CC_POP;
                res_value  = cell_value[0];
                count_next = count - CW'(1);
              end else begin
                // hold the result until the target reaches cell 0
                res_load      = 1'b0;
                swap_pos_next = depth_from_top;
                state_next    = sop_pkg::S_SWAP;
              end
            end
            default: ;  // unused action: nothing changes, status ok
          endcase
        end
      end
      sop_pkg::S_SWAP: begin
        // advance the target one cell toward the top
        cmd           = sop_pkg::CC_SWAP;
        swap_pos_next = swap_pos - IW'(1);
        if (swap_pos == IW'(1)) begin
          state_next = sop_pkg::S_FINISH;
        end
      end
      sop_pkg::S_FINISH: begin
        if (slot_free) begin
          cmd        = sop_pkg::CC_POP;
          res_load   = 1'b1;
          res_value  = cell_value[0];
          count_next = count - CW'(1);
          state_next = sop_pkg::S_IDLE;
        end
      end
      default: state_next = sop_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= sop_pkg::S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (res_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    swap_pos <= swap_pos_next;
    if (res_load) begin
      rsp_value  <= res_value;
      rsp_status <= res_status;
      rsp_count  <= sop_pkg::COUNT_W'(count_next);
    end
  end

  assign rsp.valid         = rsp_valid;
  assign rsp.popped_value  = rsp_value;
  assign rsp.status        = rsp_status;
  assign rsp.element_count = rsp_count;

  // Cell 0 is the top; cell j takes from j-1 on push and from j+1 on pop.
  for (genvar j = 0; j < TOTAL_DEPTH; j++) begin : g_cell
    logic [DW-1:0] left_in;
    logic [DW-1:0] right_in;

    if (j == 0) begin : g_first
      assign left_in = req.push_value;
    end else begin : g_inner_l
      assign left_in = cell_value[j-1];
    end

    if (j == TOTAL_DEPTH - 1) begin : g_last
      assign right_in = cell_value[j];
    end else begin : g_inner_r
      assign right_in = cell_value[j+1];
    end

    sop_cell #(
      .IW    (IW),
      .INDEX (j)
    ) u_cell (
      .clk      (clk),
      .cmd      (cmd),
      .swap_pos (swap_pos),
      .left     (left_in),
      .right    (right_in),
      .value    (cell_value[j])
    );
  end

endmodule

// File: hdl/sop_cell.sv
// One storage cell of the stack row; trades its value with its neighbors.
// Depends on sop_pkg for the cell command type and data width.
module sop_cell #(
  parameter int IW    = 6,
  parameter int INDEX = 0
) (
  input  logic                          clk,
  input  sop_pkg::cell_cmd_t            cmd,
  input  logic [IW-1:0]                 swap_pos,
  input  logic [sop_pkg::DATA_W-1:0]    left,
  input  logic [sop_pkg::DATA_W-1:0]    right,
  output logic [sop_pkg::DATA_W-1:0]    value
);

  logic is_hi;
  logic is_lo;

  assign is_hi = ({1'b0, swap_pos} == (IW+1)'(INDEX));
  assign is_lo = ({1'b0, swap_pos} == (IW+1)'(INDEX + 1));

  always_ff @(posedge clk) begin
    unique case (cmd)
      sop_pkg::CC_PUSH: value <= left;
      sop_pkg::CC_POP:  value <= right;
      sop_pkg::CC_SWAP: begin
        if (is_hi) begin
          value <= left;
        end else if (is_lo) begin
          value <= right;
        end
      end
      default: ;
    endcase
  end

endmodule
